@@ rtl/order_statistic_multiset_core_macros.svh @@
// Assertion macros used by the checker.
`ifndef ORDER_STATISTIC_MULTISET_CORE_MACROS_SVH
`define ORDER_STATISTIC_MULTISET_CORE_MACROS_SVH

// property checked on every edge outside reset
`define OSM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge, reset included
`define OSM_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/osm_pkg.sv @@
`default_nettype none
package osm_pkg;

   localparam int CAPACITY = 1024;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;

   localparam logic [2:0] OP_INSERT = 3'd0;
   localparam logic [2:0] OP_DELETE = 3'd1;
   localparam logic [2:0] OP_RANK   = 3'd2;
   localparam logic [2:0] OP_SELECT = 3'd3;
   localparam logic [2:0] OP_PRED   = 3'd4;
   localparam logic [2:0] OP_SUCC   = 3'd5;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_MISS = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   localparam logic signed [DATA_W-1:0] SENT_HIGH = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] SENT_LOW  = 32'sh8000_0001;
   localparam logic signed [DATA_W-1:0] NO_SELECT = 32'shFFFF_FFFF;

   typedef struct packed {
      logic              rd_en;
      logic [IDX_W-1:0]  rd_addr;
      logic              wr_en;
      logic [IDX_W-1:0]  wr_addr;
      logic [DATA_W-1:0] wr_data;
   } ram_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] answer;
      logic [1:0]               status;
   } res_type;

endpackage
`default_nettype wire

@@ rtl/osm_ram.sv @@
`default_nettype none
module osm_ram (
   input  wire logic                       clock,
   input  wire osm_pkg::ram_req_type       ram_req,
   output logic [osm_pkg::DATA_W-1:0]      rd_data
);
   import osm_pkg::*;

   logic [DATA_W-1:0] mem [CAPACITY];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ rtl/osm_ctrl.sv @@
`default_nettype none
module osm_ctrl (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [2:0]                      req_op,
   input  wire logic signed [osm_pkg::DATA_W-1:0] req_operand,
   output osm_pkg::ram_req_type                 ram_req,
   input  wire logic [osm_pkg::DATA_W-1:0]      ram_rd_data,
   output logic                                 res_valid,
   input  wire logic                            res_ready,
   output osm_pkg::res_type                     res
);
   import osm_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_SRCH, S_CMP, S_SHIFT, S_PLACE,
      S_DCHK, S_DSHIFT, S_DEND, S_ANS, S_DONE
   } state_type;

   state_type                state_ff, state_in;
   logic [2:0]               op_ff, op_in;
   logic signed [DATA_W-1:0] operand_ff, operand_in;
   logic [CNT_W-1:0]         lo_ff, lo_in, hi_ff, hi_in;
   logic [CNT_W-1:0]         ptr_ff, ptr_in, count_ff, count_in;
   logic [IDX_W-1:0]         mid_ff, mid_in;
   logic                     pend_ff, pend_in;
   logic [IDX_W-1:0]         pend_addr_ff, pend_addr_in;
   res_type                  res_ff, res_in;

   logic [CNT_W:0]           mid_sum;
   logic [IDX_W-1:0]         mid;
   logic [IDX_W-1:0]         pos_idx, pos_m1;
   logic [CNT_W-1:0]         ptr_m1, ptr_p1;
   logic signed [DATA_W-1:0] sel_m1, rd_s;
   logic                     sel_ok, strict, go_right;

   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid      = mid_sum[IDX_W:1];
   assign pos_idx  = lo_ff[IDX_W-1:0];
   assign pos_m1   = pos_idx - IDX_W'(1);
   assign ptr_m1   = ptr_ff - CNT_W'(1);
   assign ptr_p1   = ptr_ff + CNT_W'(1);
   assign sel_m1   = req_operand - 32'sd1;
   assign sel_ok   = (req_operand > 32'sd0) &&
                     (req_operand <= $signed({{(DATA_W-CNT_W){1'b0}}, count_ff}));
   assign rd_s     = $signed(ram_rd_data);
   assign strict   = (op_ff != OP_INSERT) && (op_ff != OP_SUCC);
   assign go_right = strict ? (rd_s < operand_ff) : (rd_s <= operand_ff);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      operand_in   = operand_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      ptr_in       = ptr_ff;
      count_in     = count_ff;
      mid_in       = mid_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      res_in       = res_ff;
      ram_req      = '0;
      // delayed half of a shift: write back the word read last cycle
      if (pend_ff) begin
         ram_req.wr_en   = 1'b1;
         ram_req.wr_addr = pend_addr_ff;
         ram_req.wr_data = ram_rd_data;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in         = req_op;
               operand_in    = req_operand;
               lo_in         = '0;
               hi_in         = count_ff;
               ptr_in        = count_ff;
               res_in.answer = '0;
               res_in.status = STATUS_OK;
               state_in      = S_SRCH;
               case (req_op) inside
                  OP_INSERT: begin
                     if (count_ff == CNT_W'(CAPACITY)) begin
                        res_in.status = STATUS_FULL;
                        state_in      = S_DONE;
                     end
                  end
                  OP_DELETE, OP_RANK, OP_PRED, OP_SUCC: begin
                     state_in = S_SRCH;
                  end
                  OP_SELECT: begin
                     if (sel_ok) begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = sel_m1[IDX_W-1:0];
                        state_in        = S_ANS;
                     end else begin
                        res_in.answer = NO_SELECT;
                        res_in.status = STATUS_MISS;
                        state_in      = S_DONE;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_SRCH: begin
            if (lo_ff < hi_ff) begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = mid;
               mid_in          = mid;
               state_in        = S_CMP;
            end else begin
               case (op_ff) inside
                  OP_INSERT: state_in = S_SHIFT;
                  OP_DELETE: begin
                     if (lo_ff < count_ff) begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = pos_idx;
                        ptr_in          = lo_ff;
                        state_in        = S_DCHK;
                     end else begin
                        res_in.status = STATUS_MISS;
                        state_in      = S_DONE;
                     end
                  end
                  OP_RANK: begin
                     res_in.answer = $signed(DATA_W'(lo_ff) + DATA_W'(1));
                     state_in      = S_DONE;
                  end
                  OP_PRED: begin
                     if (lo_ff != '0) begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = pos_m1;
                        state_in        = S_ANS;
                     end else begin
                        res_in.answer = SENT_LOW;
                        res_in.status = STATUS_MISS;
                        state_in      = S_DONE;
                     end
                  end
                  default: begin
                     if (lo_ff < count_ff) begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = pos_idx;
                        state_in        = S_ANS;
                     end else begin
                        res_in.answer = SENT_HIGH;
                        res_in.status = STATUS_MISS;
                        state_in      = S_DONE;
                     end
                  end
               endcase
            end
         end
         S_CMP: begin
            if (go_right) begin
               lo_in = CNT_W'(mid_ff) + CNT_W'(1);
            end else begin
               hi_in = CNT_W'(mid_ff);
            end
            state_in = S_SRCH;
         end
         S_SHIFT: begin
            if (ptr_ff > lo_ff) begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = ptr_m1[IDX_W-1:0];
               pend_in         = 1'b1;
               pend_addr_in    = ptr_ff[IDX_W-1:0];
               ptr_in          = ptr_m1;
            end else begin
               state_in = S_PLACE;
            end
         end
         S_PLACE: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = pos_idx;
            ram_req.wr_data = operand_ff;
            count_in        = count_ff + CNT_W'(1);
            state_in        = S_DONE;
         end
         S_DCHK: begin
            if (rd_s == operand_ff) begin
               state_in = S_DSHIFT;
            end else begin
               res_in.status = STATUS_MISS;
               state_in      = S_DONE;
            end
         end
         S_DSHIFT: begin
            if (ptr_p1 < count_ff) begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = ptr_p1[IDX_W-1:0];
               pend_in         = 1'b1;
               pend_addr_in    = ptr_ff[IDX_W-1:0];
               ptr_in          = ptr_p1;
            end else begin
               state_in = S_DEND;
            end
         end
         S_DEND: begin
            count_in = count_ff - CNT_W'(1);
            state_in = S_DONE;
         end
         S_ANS: begin
            res_in.answer = rd_s;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
      op_ff        <= op_in;
      operand_ff   <= operand_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      ptr_ff       <= ptr_in;
      mid_ff       <= mid_in;
      pend_addr_ff <= pend_addr_in;
      res_ff       <= res_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res       = res_ff;

endmodule
`default_nettype wire

@@ rtl/osm_out.sv @@
`default_nettype none
module osm_out (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              res_valid,
   output logic                                   res_ready,
   input  wire osm_pkg::res_type                  res,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic signed [osm_pkg::DATA_W-1:0]      rsp_answer,
   output logic [1:0]                             rsp_status
);
   import osm_pkg::*;

   logic    valid_ff;
   res_type word_ff;

   assign res_ready = !valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (res_ready) begin
         valid_ff <= res_valid;
      end
      if (res_ready && res_valid) begin
         word_ff <= res;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_answer = word_ff.answer;
   assign rsp_status = word_ff.status;

endmodule
`default_nettype wire

@@ rtl/order_statistic_multiset_core.sv @@
// Sorted multiset of signed 32-bit values with rank / select / neighbor queries.
// Request channel (req_valid/req_ready): req_op and req_operand. Insert, delete,
// rank, select, predecessor and successor; each request yields one response
// word on rsp_valid/rsp_ready carrying rsp_answer and rsp_status.
// One request is in flight at a time; req_ready is high only when idle.
// Lookups use a binary search over the sorted RAM; each probe reads the middle
// entry and then compares it. Select reads its entry directly by index.
// Insert and delete then move the entries above the position one per cycle
// through the single-port-pair RAM.
// The response sits in an output register: once it is handed over the core
// goes idle and takes the next request even if rsp_ready stays low; a second
// finished response waits inside the core until the register frees up.
// Reset (synchronous) empties the set and drops any pending response; the
// RAM contents are not cleared and need no clearing pass.
`default_nettype none
module order_statistic_multiset_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [2:0]                        req_op,
   input  wire logic signed [osm_pkg::DATA_W-1:0] req_operand,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic signed [osm_pkg::DATA_W-1:0]      rsp_answer,
   output logic [1:0]                             rsp_status
);
   import osm_pkg::*;

   ram_req_type       ram_req;
   logic [DATA_W-1:0] ram_rd_data;
   logic              res_valid;
   logic              res_ready;
   res_type           res;

   osm_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (ram_rd_data)
   );

   osm_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_op      (req_op),
      .req_operand (req_operand),
      .ram_req     (ram_req),
      .ram_rd_data (ram_rd_data),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res)
   );

   osm_out u_out (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res        (res),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_answer (rsp_answer),
      .rsp_status (rsp_status)
   );

endmodule
`default_nettype wire

@@ rtl/osm_checker.sv @@
`default_nettype none
`include "order_statistic_multiset_core_macros.svh"
module osm_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_ready,
   input wire logic [2:0]                        req_op,
   input wire logic signed [osm_pkg::DATA_W-1:0] req_operand,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic signed [osm_pkg::DATA_W-1:0] rsp_answer,
   input wire logic [1:0]                        rsp_status
);
   import osm_pkg::*;

   logic              req_fire, req_stall, rsp_stall, full_word;
   logic [DATA_W+3:0] req_word;
   logic [DATA_W+2:0] rsp_word;

   assign req_fire  = req_valid && req_ready;
   assign req_stall = req_valid && !req_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign full_word = rsp_valid && (rsp_status == STATUS_FULL);
   assign req_word  = {req_valid, req_op, req_operand};
   assign rsp_word  = {rsp_valid, rsp_answer, rsp_status};

   `OSM_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !rsp_valid, "response valid after reset")
   `OSM_ASSERT(a_rsp_hold, clock, reset, rsp_stall |=> $stable(rsp_word), "response word changed")
   `OSM_ASSERT(a_req_hold, clock, reset, req_stall |=> $stable(req_word), "request word changed")
   `OSM_ASSERT(a_one_in_flight, clock, reset, req_fire |=> !req_ready, "request taken while busy")
   `OSM_ASSERT(a_full_answer, clock, reset, full_word |-> rsp_answer == '0, "answer set on full")

endmodule

bind order_statistic_multiset_core osm_checker u_osm_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_op      (req_op),
   .req_operand (req_operand),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_answer  (rsp_answer),
   .rsp_status  (rsp_status)
);
`default_nettype wire

@@ test/order_statistic_multiset_checker.sv @@
`timescale 1ns / 100ps
module order_statistic_multiset_checker
   import osm_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic                     req_ready,
   input  wire logic [2:0]               req_op,
   input  wire logic signed [DATA_W-1:0] req_operand,
   input  wire logic                     rsp_valid,
   input  wire logic                     rsp_ready,
   input  wire logic signed [DATA_W-1:0] rsp_answer,
   input  wire logic [1:0]               rsp_status,
   output int                            failures,
   output int                            outstanding
);

   // sorted copy of the multiset, duplicates side by side
   logic signed [DATA_W-1:0] held [$];
   res_type                  due_answers [$];
   int                       mismatch_count = 0;
   int                       waiting = 0;

   assign failures    = mismatch_count;
   assign outstanding = waiting;

   function automatic int count_below(logic signed [DATA_W-1:0] v);
      int n = 0;
      while (n < held.size() && held[n] < v) n++;
      return n;
   endfunction

   function automatic int count_upto(logic signed [DATA_W-1:0] v);
      int n = 0;
      while (n < held.size() && held[n] <= v) n++;
      return n;
   endfunction

   function automatic res_type apply_op(logic [2:0] op, logic signed [DATA_W-1:0] v);
      res_type r;
      int      pos;
      r.answer = '0;
      r.status = STATUS_OK;
      case (op)
         OP_INSERT: begin
            if (held.size() >= CAPACITY) r.status = STATUS_FULL;
            else held.insert(count_upto(v), v);
         end
         OP_DELETE: begin
            pos = count_below(v);
            if (pos < held.size() && held[pos] == v) held.delete(pos);
            else r.status = STATUS_MISS;
         end
         OP_RANK: begin
            r.answer = count_below(v) + 1;
         end
         OP_SELECT: begin
            if (v >= 1 && v <= held.size()) begin
               r.answer = held[v - 1];
            end else begin
               r.answer = NO_SELECT;
               r.status = STATUS_MISS;
            end
         end
         OP_PRED: begin
            pos = count_below(v);
            if (pos > 0) begin
               r.answer = held[pos - 1];
            end else begin
               r.answer = SENT_LOW;
               r.status = STATUS_MISS;
            end
         end
         OP_SUCC: begin
            pos = count_upto(v);
            if (pos < held.size()) begin
               r.answer = held[pos];
            end else begin
               r.answer = SENT_HIGH;
               r.status = STATUS_MISS;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin : watch
      res_type want;
      if (reset) begin
         held.delete();
         due_answers.delete();
         waiting <= 0;
      end else begin
         if (req_valid && req_ready) due_answers.push_back(apply_op(req_op, req_operand));
         if (rsp_valid && rsp_ready) begin
            if (due_answers.size() == 0) begin
               $error("unexpected response word: answer %0d status %0d",
                      rsp_answer, rsp_status);
               mismatch_count++;
            end else begin
               want = due_answers.pop_front();
               if (rsp_answer !== want.answer) begin
                  $error("answer: expected %0d, actual %0d", want.answer, rsp_answer);
                  mismatch_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  mismatch_count++;
               end
            end
         end
         waiting <= due_answers.size();
      end
   end

endmodule

@@ test/tb_order_statistic_multiset_core.sv @@
`timescale 1ns / 100ps
module tb_order_statistic_multiset_core;
   import osm_pkg::*;

   localparam logic [2:0] OP_SPARE6   = 3'd6;
   localparam logic [2:0] OP_SPARE7   = 3'd7;
   localparam int         CYCLE_LIMIT = 5_000_000;
   localparam int         HOLD_CYCLES = 400;
   localparam int         PHASE_ITEMS = 110;
   localparam int         FILL_ITEMS  = 64;
   localparam int         RECENT_N    = 64;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [2:0]               req_op = OP_INSERT;
   logic signed [DATA_W-1:0] req_operand = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [DATA_W-1:0] rsp_answer;
   logic [1:0]               rsp_status;

   int                       failures;
   int                       outstanding;
   int                       sender_idle = 0;
   int                       stall_pct = 0;
   logic                     hold_go = 1'b0;
   int                       cycle_count = 0;
   logic signed [DATA_W-1:0] recent [RECENT_N];
   int                       recent_wr = 0;

   order_statistic_multiset_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_op      (req_op),
      .req_operand (req_operand),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_answer  (rsp_answer),
      .rsp_status  (rsp_status)
   );

   order_statistic_multiset_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_op      (req_op),
      .req_operand (req_operand),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_answer  (rsp_answer),
      .rsp_status  (rsp_status),
      .failures    (failures),
      .outstanding (outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // response side: random stalls, plus one long hold-off
   initial begin : receiver
      int hold_left;
      logic hold_used;
      hold_left = 0;
      hold_used = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_go && !hold_used) begin
            hold_left = HOLD_CYCLES;
            hold_used = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   function automatic logic signed [DATA_W-1:0] pick_value(int recent_pct);
      int r;
      int span;
      int near;
      r    = $urandom_range(99);
      span = (recent_wr < RECENT_N) ? recent_wr : RECENT_N;
      near = $urandom_range(16);
      if (span > 0 && $urandom_range(99) < recent_pct) return recent[$urandom_range(span - 1)];
      if (r < 45) return near - 8;
      if (r < 60) begin
         case ($urandom_range(5))
            0:       return 32'sh8000_0000;
            1:       return 32'sh8000_0001;
            2:       return 32'sh7FFF_FFFF;
            3:       return 32'sh7FFF_FFFE;
            4:       return 32'sh0000_0000;
            default: return -32'sd1;
         endcase
      end
      return $urandom;
   endfunction

   task automatic send_word(input logic [2:0] op, input logic signed [DATA_W-1:0] val);
      while ($urandom_range(99) < sender_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_op      <= op;
      req_operand <= val;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (op == OP_INSERT) begin
         recent[recent_wr % RECENT_N] = val;
         recent_wr++;
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic send_random();
      int r;
      int pick;
      logic signed [DATA_W-1:0] k;
      r    = $urandom_range(99);
      pick = $urandom_range(9);
      if (pick < 8) k = $urandom_range(90);
      else if (pick == 8) k = pick_value(0);
      else k = $urandom;
      if (r < 28) send_word(OP_INSERT, pick_value(20));
      else if (r < 48) send_word(OP_DELETE, pick_value(60));
      else if (r < 60) send_word(OP_RANK, pick_value(30));
      else if (r < 74) send_word(OP_SELECT, k);
      else if (r < 86) send_word(OP_PRED, pick_value(30));
      else if (r < 97) send_word(OP_SUCC, pick_value(30));
      else send_word($urandom_range(1) ? OP_SPARE6 : OP_SPARE7, $urandom);
   endtask

   initial begin : stimulus
      int ph;
      int i;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // empty store, then extremes and duplicates
      send_word(OP_PRED,   32'sd0);
      send_word(OP_SUCC,   32'sd0);
      send_word(OP_SELECT, 32'sd1);
      send_word(OP_DELETE, 32'sd5);
      send_word(OP_RANK,   32'sd0);
      send_word(OP_INSERT, 32'sh8000_0000);
      send_word(OP_INSERT, 32'sh7FFF_FFFF);
      send_word(OP_INSERT, 32'sd0);
      send_word(OP_INSERT, 32'sd0);
      send_word(OP_INSERT, -32'sd1);
      send_word(OP_RANK,   32'sd0);
      send_word(OP_SELECT, 32'sd1);
      send_word(OP_SELECT, 32'sd5);
      send_word(OP_SELECT, 32'sd6);
      send_word(OP_SELECT, 32'sd0);
      send_word(OP_SELECT, -32'sd1);
      send_word(OP_SELECT, 32'sh8000_0000);
      send_word(OP_PRED,   32'sh8000_0000);
      send_word(OP_SUCC,   32'sh7FFF_FFFF);
      send_word(OP_PRED,   32'sd0);
      send_word(OP_SUCC,   32'sd0);
      send_word(OP_DELETE, 32'sd0);
      send_word(OP_DELETE, 32'sd3);
      send_word(OP_SPARE6, 32'sh7FFF_FFFF);
      send_word(OP_SPARE7, 32'sh8000_0000);
      send_word(OP_DELETE, 32'sh8000_0000);
      send_word(OP_DELETE, 32'sh7FFF_FFFF);

      // ascending fill, then shifts across the whole store
      for (i = 0; i < FILL_ITEMS; i++) send_word(OP_INSERT, 100 + 7 * i);
      send_word(OP_DELETE, -32'sd1);
      send_word(OP_INSERT, -32'sd1);
      send_word(OP_INSERT, 32'sd5);
      send_word(OP_RANK,   32'sh7FFF_FFFF);
      send_word(OP_SELECT, CAPACITY);
      send_word(OP_SELECT, CAPACITY + 1);
      send_word(OP_PRED,   32'sh7FFF_FFFF);
      send_word(OP_SUCC,   32'sh8000_0000);
      for (i = FILL_ITEMS - 1; i >= 20; i--) send_word(OP_DELETE, 100 + 7 * i);
      wait_drained();

      for (ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               sender_idle = 0;
               stall_pct  <= 0;
               hold_go    <= 1'b1;
            end
            1: begin
               sender_idle = 81;
               stall_pct  <= 0;
            end
            2: begin
               sender_idle = 0;
               stall_pct  <= 81;
            end
            default: begin
               sender_idle = 38;
               stall_pct  <= 38;
            end
         endcase
         for (i = 0; i < PHASE_ITEMS; i++) send_random();
         wait_drained();
      end

      stall_pct <= 0;
      repeat (100) @(posedge clock);
      if (failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
